/* hdl/kdb_pkg.sv */
package kdb_pkg;

	localparam int KEY_W = 16;
	localparam int IDX_W = 4;
	localparam int CNT_W = 5;
	localparam int PH_W = 5;

	localparam logic [PH_W-1:0] PH_UNSTABLE   = 5'h01;
	localparam logic [PH_W-1:0] PH_PRESSED    = 5'h02;
	localparam logic [PH_W-1:0] PH_NOTPRESSED = 5'h04;
	localparam logic [PH_W-1:0] PH_WAIT_IRQ   = 5'h08;
	localparam logic [PH_W-1:0] PH_POLL       = 5'h10;
	localparam logic [PH_W-1:0] PH_UNKNOWN    = PH_PRESSED | PH_NOTPRESSED;

	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

	localparam logic [1:0] CFG_ACTIVE_HIGH = 2'd0;
	localparam logic [1:0] CFG_USE_IRQ     = 2'd1;
	localparam logic [1:0] CFG_KEY_COUNT   = 2'd2;
	localparam logic [1:0] CFG_DEBOUNCE    = 2'd3;

	localparam logic       ACT_TICK = 1'b0;
	localparam logic       ACT_EDGE = 1'b1;

	localparam logic [1:0] TMR_NONE     = 2'd0;
	localparam logic [1:0] TMR_DEBOUNCE = 2'd1;
	localparam logic [1:0] TMR_POLL     = 2'd2;

	localparam logic [1:0] WAKE_NONE    = 2'd0;
	localparam logic [1:0] WAKE_ACQUIRE = 2'd1;
	localparam logic [1:0] WAKE_RELEASE = 2'd2;

	typedef struct packed {
		logic             action;
		logic [IDX_W-1:0] key_index;
		logic [KEY_W-1:0] key_levels;
	} in_item_t;

	typedef struct packed {
		logic             event_valid;
		logic [IDX_W-1:0] event_key;
		logic             event_pressed;
		logic [1:0]       timer_request;
		logic [1:0]       wake_request;
		logic [KEY_W-1:0] edge_mask;
		logic             last;
	} out_item_t;

	typedef struct packed {
		logic            phase_we;
		logic [PH_W-1:0] phase_nxt;
		logic            cnt_inc;
		logic            cnt_dec;
		logic            edge_set;
		logic            edge_clr;
		logic            emit;
		logic            wake_acq;
	} step_t;

endpackage

/* hdl/multi_key_debounce_scanner.sv */
// Key debouncer. A tick transaction walks the keys in use one per cycle through a
// single phase-step unit, unless an event is held up by a stalled output, emitting
// one event transaction per key that turns stable, then one status transaction
// (last=1) with timer/wake requests and the edge mask. Keys in use are at most 16.
// in_ready is high only between transactions, so no new transaction is taken while
// one is in flight. Writing key_count resets all key phases, the pending counter and
// the edge mask in the same cycle.
module multi_key_debounce_scanner import kdb_pkg::*; #(
	parameter int NKEYS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_item_t  out_item,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [4:0] cfg_data
);

	localparam int NPH = (NKEYS < 16) ? NKEYS : 16;
	localparam int PIW = (NPH > 1) ? $clog2(NPH) : 1;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_EDGE  = 2'd2;
	localparam logic [1:0] ST_FINAL = 2'd3;

	logic [1:0]       state_q;
	logic             active_high_q, use_irq_q, debounce_q;
	logic [4:0]       key_count_q;
	logic [PH_W-1:0]  phase_q [NPH];
	logic [CNT_W-1:0] cnt_q;
	logic [KEY_W-1:0] edge_q;
	in_item_t         in_q;
	logic [IDX_W-1:0] idx_q;
	logic             acq_q;

	logic [4:0]       n, n_wr;
	logic [IDX_W-1:0] addr;
	logic             level, out_free, edge_ok, go, reinit, scan_end;
	step_t            step, eff;
	out_item_t        ev_item, fin_item;

	assign n = (key_count_q > 5'(NPH)) ? 5'(NPH) : key_count_q;
	assign n_wr = (cfg_data > 5'(NPH)) ? 5'(NPH) : cfg_data;
	assign reinit = cfg_we && cfg_index == CFG_KEY_COUNT;

	assign addr = (state_q == ST_EDGE) ? in_q.key_index : idx_q;
	assign level = in_q.key_levels[addr] ^ ~active_high_q;
	assign edge_ok = use_irq_q && {1'b0, in_q.key_index} < n && edge_q[in_q.key_index];
	assign out_free = !out_valid || out_ready;
	assign in_ready = state_q == ST_IDLE;
	assign scan_end = 5'({1'b0, idx_q} + 5'd1) >= n;

	kdb_step u_step (
		.phase      (phase_q[addr[PIW-1:0]]),
		.level      (level),
		.is_edge    (state_q == ST_EDGE),
		.use_irq    (use_irq_q),
		.debounce_en(debounce_q),
		.cnt_zero   (cnt_q == '0),
		.step       (step)
	);

	always_comb begin
		eff = '0;
		if (state_q == ST_SCAN || (state_q == ST_EDGE && edge_ok))
			eff = step;
	end

	assign go = (state_q == ST_SCAN || state_q == ST_EDGE) && (!eff.emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_high_q <= 1'b0;
			use_irq_q <= 1'b1;
			key_count_q <= 5'd16;
			debounce_q <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ACTIVE_HIGH: active_high_q <= cfg_data[0];
				CFG_USE_IRQ:     use_irq_q <= cfg_data[0];
				CFG_KEY_COUNT:   key_count_q <= cfg_data;
				CFG_DEBOUNCE:    debounce_q <= cfg_data[0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NPH; i++)
				phase_q[i] <= PH_UNKNOWN;
			cnt_q <= 5'(NPH);
			edge_q <= '1;
		end else if (reinit) begin
			for (int i = 0; i < NPH; i++)
				phase_q[i] <= PH_UNKNOWN;
			cnt_q <= n_wr;
			edge_q <= '1;
		end else if (go) begin
			if (eff.phase_we)
				phase_q[addr[PIW-1:0]] <= eff.phase_nxt;
			if (eff.cnt_inc && cnt_q != CNT_MAX)
				cnt_q <= cnt_q + 5'd1;
			if (eff.cnt_dec && cnt_q != '0)
				cnt_q <= cnt_q - 5'd1;
			if (eff.edge_set)
				edge_q <= edge_q | (KEY_W'(1) << addr);
			if (eff.edge_clr)
				edge_q <= edge_q & ~(KEY_W'(1) << addr);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			acq_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						idx_q <= '0;
						acq_q <= 1'b0;
						if (in_item.action == ACT_EDGE)
							state_q <= ST_EDGE;
						else if (n == '0)
							state_q <= ST_FINAL;
						else
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (go) begin
						idx_q <= idx_q + IDX_W'(1);
						if (scan_end)
							state_q <= ST_FINAL;
					end
				end
				ST_EDGE: begin
					if (go) begin
						acq_q <= eff.wake_acq;
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			in_q <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (go && eff.emit) begin
			out_valid <= 1'b1;
		end else if (state_q == ST_FINAL && out_free) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_comb begin
		ev_item = '0;
		ev_item.event_valid = 1'b1;
		ev_item.event_key = addr;
		ev_item.event_pressed = level;
		fin_item = '0;
		fin_item.edge_mask = edge_q;
		fin_item.last = 1'b1;
		if (in_q.action == ACT_TICK) begin
			if (cnt_q != '0)
				fin_item.timer_request = TMR_DEBOUNCE;
			else if (!use_irq_q)
				fin_item.timer_request = TMR_POLL;
			else
				fin_item.wake_request = WAKE_RELEASE;
		end else if (acq_q) begin
			fin_item.timer_request = TMR_DEBOUNCE;
			fin_item.wake_request = WAKE_ACQUIRE;
		end
	end

	always_ff @(posedge clk) begin
		if (go && eff.emit)
			out_item <= ev_item;
		else if (state_q == ST_FINAL && out_free)
			out_item <= fin_item;
	end

`ifndef SYNTHESIS
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> {1'b0, idx_q} < n)
		else $error("scan index beyond keys in use");

	a_final_no_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last |-> !out_item.event_valid)
		else $error("status transaction flagged as event");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("sequencer idle after accepting a transaction");
`endif

endmodule

/* hdl/kdb_step.sv */
module kdb_step import kdb_pkg::*; (
	input  logic [PH_W-1:0] phase,
	input  logic            level,
	input  logic            is_edge,
	input  logic            use_irq,
	input  logic            debounce_en,
	input  logic            cnt_zero,
	output step_t           step
);

	logic [PH_W-1:0] d;

	always_comb begin
		step = '0;
		d = (phase & PH_UNSTABLE) != '0 ? PH_UNKNOWN : phase;
		if (is_edge) begin
			if (debounce_en) begin
				step.phase_we = 1'b1;
				if ((phase & PH_WAIT_IRQ) != '0) begin
					step.phase_nxt = PH_UNKNOWN;
					step.cnt_inc = 1'b1;
					step.wake_acq = cnt_zero;
				end else begin
					step.phase_nxt = PH_UNSTABLE;
					step.edge_clr = 1'b1;
				end
			end else begin
				step.emit = 1'b1;
			end
		end else if ((phase & PH_WAIT_IRQ) == '0) begin
			step.phase_we = 1'b1;
			step.edge_set = (phase & PH_UNSTABLE) != '0;
			step.phase_nxt = d;
			if ((d & PH_POLL) != '0) begin
				if (level != ((d & PH_PRESSED) != '0)) begin
					step.cnt_inc = 1'b1;
					step.phase_nxt = PH_UNKNOWN;
				end
			end else if (level && (d & PH_NOTPRESSED) != '0) begin
				step.phase_nxt = PH_PRESSED;
			end else if (!level && (d & PH_PRESSED) != '0) begin
				step.phase_nxt = PH_NOTPRESSED;
			end else begin
				step.cnt_dec = 1'b1;
				step.emit = 1'b1;
				step.phase_nxt = d | (use_irq ? PH_WAIT_IRQ : PH_POLL);
			end
		end
	end

endmodule

/* test/multi_key_debounce_scanner_tb.sv */
module multi_key_debounce_scanner_tb;
	import kdb_pkg::*;

	localparam int NUM_KEYS = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [4:0] cfg_data = '0;

	multi_key_debounce_scanner #(.NKEYS(NUM_KEYS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of config and key state
	logic cfg_active_high;
	logic cfg_irq;
	logic [4:0] cfg_keys;
	logic cfg_debounce;
	logic [PH_W-1:0] key_phase [NUM_KEYS];
	logic [CNT_W-1:0] pend_cnt;
	logic [KEY_W-1:0] edge_en;

	in_item_t scan_q [$];
	out_item_t report_q [$];

	int send_idle = 0;
	int rx_idle = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int bad_cnt = 0;
	int cycles = 0;
	logic [KEY_W-1:0] lvl_track = '0;

	function automatic int keys_in_use();
		return (cfg_keys > NUM_KEYS) ? NUM_KEYS : int'(cfg_keys);
	endfunction

	function automatic logic level_of(logic [KEY_W-1:0] lv, int i);
		return lv[i] ^ ~cfg_active_high;
	endfunction

	task automatic reinit_keys();
		for (int i = 0; i < NUM_KEYS; i++)
			key_phase[i] = PH_UNKNOWN;
		pend_cnt = CNT_W'(keys_in_use());
		edge_en = '1;
	endtask

	task automatic apply_cfg(logic [1:0] idx, logic [4:0] val);
		case (idx)
			CFG_ACTIVE_HIGH: cfg_active_high = val[0];
			CFG_USE_IRQ: cfg_irq = val[0];
			CFG_KEY_COUNT: begin
				cfg_keys = val;
				reinit_keys();
			end
			CFG_DEBOUNCE: cfg_debounce = val[0];
			default: ;
		endcase
	endtask

	task automatic debounce_step(in_item_t it);
		out_item_t rep;
		logic [PH_W-1:0] d;
		logic p;
		logic was;
		logic [1:0] tmr;
		logic [1:0] wk;
		int n;
		n = keys_in_use();
		tmr = TMR_NONE;
		wk = WAKE_NONE;
		if (it.action == ACT_TICK) begin
			for (int i = 0; i < n; i++) begin
				d = key_phase[i];
				if ((d & PH_WAIT_IRQ) != 0)
					continue;
				if ((d & PH_UNSTABLE) != 0) begin
					d = PH_UNKNOWN;
					key_phase[i] = d;
					edge_en[i] = 1'b1;
				end
				p = level_of(it.key_levels, i);
				if ((d & PH_POLL) != 0) begin
					was = (d & PH_PRESSED) != 0;
					if (p != was) begin
						if (pend_cnt != CNT_MAX)
							pend_cnt++;
						key_phase[i] = PH_UNKNOWN;
					end
					continue;
				end
				if (p && (d & PH_NOTPRESSED) != 0) begin
					key_phase[i] = PH_PRESSED;
					continue;
				end
				if (!p && (d & PH_PRESSED) != 0) begin
					key_phase[i] = PH_NOTPRESSED;
					continue;
				end
				if (pend_cnt != 0)
					pend_cnt--;
				key_phase[i] = d | (cfg_irq ? PH_WAIT_IRQ : PH_POLL);
				rep = '0;
				rep.event_valid = 1'b1;
				rep.event_key = IDX_W'(i);
				rep.event_pressed = p;
				report_q.push_back(rep);
			end
			if (pend_cnt != 0)
				tmr = TMR_DEBOUNCE;
			else if (!cfg_irq)
				tmr = TMR_POLL;
			else
				wk = WAKE_RELEASE;
		end else if (cfg_irq && int'(it.key_index) < n && edge_en[it.key_index]) begin
			if (cfg_debounce) begin
				if ((key_phase[it.key_index] & PH_WAIT_IRQ) != 0) begin
					key_phase[it.key_index] = PH_UNKNOWN;
					if (pend_cnt == 0) begin
						wk = WAKE_ACQUIRE;
						tmr = TMR_DEBOUNCE;
					end
					if (pend_cnt != CNT_MAX)
						pend_cnt++;
				end else begin
					edge_en[it.key_index] = 1'b0;
					key_phase[it.key_index] = PH_UNSTABLE;
				end
			end else begin
				rep = '0;
				rep.event_valid = 1'b1;
				rep.event_key = it.key_index;
				rep.event_pressed = level_of(it.key_levels, int'(it.key_index));
				report_q.push_back(rep);
			end
		end
		rep = '0;
		rep.timer_request = tmr;
		rep.wake_request = wk;
		rep.edge_mask = edge_en;
		rep.last = 1'b1;
		report_q.push_back(rep);
	endtask

	task automatic note_bad(string what, out_item_t want, out_item_t got);
		bad_cnt++;
		if (bad_cnt <= 10) begin
			$write("%s: exp v=%0d k=%0d p=%0d t=%0d w=%0d m=%h l=%0d",
				what, want.event_valid, want.event_key, want.event_pressed,
				want.timer_request, want.wake_request, want.edge_mask, want.last);
			$display(" got v=%0d k=%0d p=%0d t=%0d w=%0d m=%h l=%0d",
				got.event_valid, got.event_key, got.event_pressed,
				got.timer_request, got.wake_request, got.edge_mask, got.last);
		end
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				debounce_step(in_item);
			if (!in_valid || in_ready) begin
				if (scan_q.size() != 0 && $urandom_range(99) >= send_idle) begin
					in_valid <= 1'b1;
					in_item <= scan_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (hold_seen != hold_req) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (report_q.size() == 0) begin
				note_bad("unexpected transaction", '0, out_item);
			end else begin
				if (out_item.event_valid !== report_q[0].event_valid ||
					out_item.event_key !== report_q[0].event_key ||
					out_item.event_pressed !== report_q[0].event_pressed ||
					out_item.timer_request !== report_q[0].timer_request ||
					out_item.wake_request !== report_q[0].wake_request ||
					out_item.edge_mask !== report_q[0].edge_mask ||
					out_item.last !== report_q[0].last)
					note_bad("mismatch", report_q[0], out_item);
				void'(report_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("multi_key_debounce_scanner_tb failed");
			$finish;
		end
	end

	task automatic push(logic act, int idx, logic [KEY_W-1:0] lv);
		in_item_t it;
		it.action = act;
		it.key_index = IDX_W'(idx);
		it.key_levels = lv;
		scan_q.push_back(it);
	endtask

	function automatic in_item_t rand_item();
		in_item_t it;
		int r;
		int span;
		r = $urandom_range(99);
		span = keys_in_use();
		if (span == 0)
			span = 1;
		if (r < 50) begin
			if ($urandom_range(3) == 0)
				lvl_track ^= KEY_W'(1) << $urandom_range(KEY_W - 1);
			it.action = ACT_TICK;
			it.key_index = IDX_W'($urandom);
			it.key_levels = lvl_track;
		end else if (r < 90) begin
			it.action = ACT_EDGE;
			it.key_index = IDX_W'($urandom_range(span - 1));
			if ($urandom_range(1) == 1)
				lvl_track ^= KEY_W'(1) << it.key_index;
			it.key_levels = lvl_track;
		end else begin
			it.action = 1'($urandom);
			it.key_index = IDX_W'($urandom);
			it.key_levels = KEY_W'($urandom);
		end
		return it;
	endfunction

	task automatic rand_burst(int cnt);
		@(negedge clk);
		for (int i = 0; i < cnt; i++)
			scan_q.push_back(rand_item());
	endtask

	task automatic settle();
		while (scan_q.size() != 0 || in_valid || report_q.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [4:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_cfg(idx, val);
	endtask

	task automatic cfg_all(logic ah, logic irq, logic [4:0] kc, logic deb);
		cfg_write(CFG_ACTIVE_HIGH, {4'd0, ah});
		cfg_write(CFG_USE_IRQ, {4'd0, irq});
		cfg_write(CFG_KEY_COUNT, kc);
		cfg_write(CFG_DEBOUNCE, {4'd0, deb});
	endtask

	initial begin
		cfg_active_high = 1'b0;
		cfg_irq = 1'b1;
		cfg_keys = 5'd16;
		cfg_debounce = 1'b1;
		reinit_keys();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: reset settings, inverted levels
		send_idle = 18;
		rx_idle = 73;
		@(negedge clk);
		push(ACT_TICK, 0, 16'hFFFF);
		push(ACT_TICK, 0, 16'hFFFF);
		push(ACT_EDGE, 0, 16'h0000);
		push(ACT_EDGE, 0, 16'h0000);
		push(ACT_EDGE, 0, 16'h0000);
		push(ACT_TICK, 0, 16'h0000);
		push(ACT_TICK, 0, 16'h0000);
		push(ACT_EDGE, 15, 16'h0000);
		push(ACT_EDGE, 7, 16'hAAAA);
		push(ACT_TICK, 0, 16'h5555);
		push(ACT_TICK, 0, 16'h5555);
		push(ACT_TICK, 0, 16'h5555);
		settle();
		cfg_write(CFG_KEY_COUNT, 5'd0);
		@(negedge clk);
		push(ACT_TICK, 0, 16'h0000);
		push(ACT_EDGE, 3, 16'h0000);
		settle();
		cfg_write(CFG_KEY_COUNT, 5'd31);
		@(negedge clk);
		push(ACT_TICK, 0, 16'h0000);
		push(ACT_TICK, 0, 16'h0000);
		settle();
		cfg_write(CFG_DEBOUNCE, 5'd0);
		@(negedge clk);
		push(ACT_EDGE, 5, 16'h0020);
		push(ACT_EDGE, 15, 16'h0000);
		settle();
		cfg_write(CFG_ACTIVE_HIGH, 5'd1);
		cfg_write(CFG_USE_IRQ, 5'd0);
		@(negedge clk);
		push(ACT_EDGE, 2, 16'h0004);
		push(ACT_TICK, 0, 16'h0000);
		push(ACT_TICK, 0, 16'h0000);
		push(ACT_TICK, 0, 16'hFFFF);
		push(ACT_TICK, 0, 16'hFFFF);
		push(ACT_TICK, 0, 16'hFFFF);
		settle();

		cfg_all(1'b1, 1'b1, 5'd16, 1'b1);
		rand_burst(30);
		settle();
		rand_burst(30);
		settle();
		cfg_all(1'b0, 1'b0, 5'd5, 1'b1);
		rand_burst(50);
		settle();

		send_idle = 73;
		rx_idle = 18;
		cfg_all(1'b1, 1'b1, 5'd1, 1'b0);
		rand_burst(30);
		settle();
		cfg_all(1'b0, 1'b1, 5'd31, 1'b1);
		rand_burst(50);
		settle();
		cfg_all(1'b1, 1'b0, 5'd16, 1'b0);
		rand_burst(30);
		settle();

		send_idle = 0;
		rx_idle = 0;
		cfg_all(1'b1, 1'b1, 5'd9, 1'b1);
		@(negedge clk);
		hold_req++;
		rand_burst(50);
		settle();
		cfg_all(1'b0, 1'b1, 5'd16, 1'b1);
		rand_burst(60);
		settle();

		repeat (20) @(posedge clk);
		if (bad_cnt == 0)
			$display("multi_key_debounce_scanner_tb passed");
		else
			$display("multi_key_debounce_scanner_tb failed");
		$finish;
	end

endmodule
